### hw/rtl/matrix_peak_finder_assert.svh
// Assertion helpers for the matrix peak finder checks.
`ifndef MATRIX_PEAK_FINDER_ASSERT_SVH
`define MATRIX_PEAK_FINDER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define MPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Consequent must hold in the same cycle as the antecedent.
`define MPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

### hw/rtl/mpf_pkg.sv
package mpf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0]  REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  REG_COLS_IN_USE = 1'b1;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET       = 7'd64;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PROBE,
        S_SCAN,
        S_NBR,
        S_LEFT,
        S_RIGHT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic done;
    } t_seq_status;

endpackage

### hw/rtl/mpf_in_if.sv
interface mpf_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] element_value;
    logic                          last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

### hw/rtl/mpf_out_if.sv
interface mpf_out_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int ROW_W       = 6,
    parameter int COL_W       = 6
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] peak_value;
    logic        [ROW_W-1:0]       peak_row;
    logic        [COL_W-1:0]       peak_column;

    modport source (output valid, output peak_value, output peak_row, output peak_column,
                    input ready);
    modport sink   (input valid, input peak_value, input peak_row, input peak_column,
                    output ready);
endinterface

### hw/rtl/matrix_peak_finder.sv
// Channel  | Dir | Payload                                   | Handshake
// i_elem   | in  | element_value, last_element               | valid/ready
// o_peak   | out | peak_value, peak_row, peak_column         | valid/ready
// i_cfg_*  | in  | i_cfg_idx, i_cfg_data                     | i_cfg_we, no wait
//
// Loading takes one element per cycle. After the transfer of the item with
// last_element set, input ready stays low until the search result is written
// to the output register. A search runs P <= floor(log2(cols)) + 1 probes:
// each probe scans one column through the single read port of the matrix RAM,
// then checks the left and right neighbor. A result waiting in the output
// register does not block loading, only the end of the next search. Reset is
// synchronous, active low; it clears control state, not the RAM.
module matrix_peak_finder #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mpf_in_if.sink                            i_elem,
    mpf_out_if.source                         o_peak,
    input  logic                              i_cfg_we,
    input  logic [mpf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mpf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mpf_pkg::*;

    localparam int DR_W  = $clog2(MAX_ROWS + 1);
    localparam int DC_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [CFG_DATA_W-1:0] r_rows_cfg, r_cols_cfg;
    logic [DR_W-1:0]       rows;
    logic [DC_W-1:0]       cols;
    t_seq_status           status;

    logic signed [VALUE_WIDTH-1:0] peak_value;
    logic [ROW_W-1:0]              peak_row;
    logic [COL_W-1:0]              peak_col;

    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic [ROW_W-1:0]              r_out_row;
    logic [COL_W-1:0]              r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= DIM_RESET;
            r_cols_cfg <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS_IN_USE: r_rows_cfg <= i_cfg_data;
                REG_COLS_IN_USE: r_cols_cfg <= i_cfg_data;
            endcase
        end
    end

    // zero reads as one, anything past the array size as the size
    always_comb begin
        priority if (r_rows_cfg == '0)              rows = DR_W'(1);
        else if (32'(r_rows_cfg) > 32'(MAX_ROWS))   rows = DR_W'(MAX_ROWS);
        else                                        rows = DR_W'(r_rows_cfg);
        priority if (r_cols_cfg == '0)              cols = DC_W'(1);
        else if (32'(r_cols_cfg) > 32'(MAX_COLS))   cols = DC_W'(MAX_COLS);
        else                                        cols = DC_W'(r_cols_cfg);
    end

    mpf_seq #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rows       (rows),
        .i_cols       (cols),
        .i_in_valid   (i_elem.valid),
        .i_elem       (i_elem.element_value),
        .i_last       (i_elem.last_element),
        .i_out_full   (r_out_valid),
        .o_status     (status),
        .o_peak_value (peak_value),
        .o_peak_row   (peak_row),
        .o_peak_col   (peak_col)
    );

    assign i_elem.ready = status.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (status.done) begin
            r_out_valid <= 1'b1;
        end else if (o_peak.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.done) begin
            r_out_value <= peak_value;
            r_out_row   <= peak_row;
            r_out_col   <= peak_col;
        end
    end

    assign o_peak.valid       = r_out_valid;
    assign o_peak.peak_value  = r_out_value;
    assign o_peak.peak_row    = r_out_row;
    assign o_peak.peak_column = r_out_col;
endmodule

### hw/rtl/mpf_store.sv
module mpf_store #(
    parameter int DEPTH       = 4096,
    parameter int ADDR_W      = 12,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic signed [VALUE_WIDTH-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    output logic signed [VALUE_WIDTH-1:0] o_rd_data
);
    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

### hw/rtl/mpf_seq.sv
module mpf_seq #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int DR_W   = $clog2(MAX_ROWS + 1),
    localparam int DC_W   = $clog2(MAX_COLS + 1),
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [DR_W-1:0]               i_rows,
    input  logic [DC_W-1:0]               i_cols,
    input  logic                          i_in_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_elem,
    input  logic                          i_last,
    input  logic                          i_out_full,
    output mpf_pkg::t_seq_status          o_status,
    output logic signed [VALUE_WIDTH-1:0] o_peak_value,
    output logic [ROW_W-1:0]              o_peak_row,
    output logic [COL_W-1:0]              o_peak_col
);
    import mpf_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W  = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    logic [ADDR_W-1:0]             r_load_pos;
    logic [COL_W-1:0]              r_low, r_high, r_probe;
    logic [ROW_W-1:0]              r_row, r_best_row;
    logic [ADDR_W-1:0]             r_addr, r_best_addr;
    logic signed [VALUE_WIDTH-1:0] r_best_val;

    logic [TOT_W-1:0]              total;
    logic [ADDR_W-1:0]             wr_addr;
    logic [TOT_W-1:0]              pos_inc;
    logic [COL_W:0]                col_sum;
    logic [COL_W-1:0]              mid;
    logic                          last_row, gt, take, left_ok, right_ok, in_xfer;
    logic [ADDR_W-1:0]             rd_addr;
    logic signed [VALUE_WIDTH-1:0] rd_data;
    logic                          wr_en;

    assign total    = TOT_W'(TOT_W'(i_rows) * TOT_W'(i_cols));
    assign wr_addr  = (TOT_W'(r_load_pos) >= total) ? '0 : r_load_pos;
    assign pos_inc  = TOT_W'(wr_addr) + 1'b1;
    assign col_sum  = {1'b0, r_low} + {1'b0, r_high};
    assign mid      = col_sum[COL_W:1];
    assign last_row = ((ROW_W + 1)'(r_row) + 1'b1) == (ROW_W + 1)'(i_rows);
    // the shared compare: every probe, scan step and neighbor check goes through it
    assign gt       = rd_data > r_best_val;
    assign take     = (r_row == '0) || gt;
    assign left_ok  = r_probe > r_low;
    assign right_ok = r_probe < r_high;
    assign in_xfer  = o_status.in_ready && i_in_valid;

    mpf_store #(
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_elem),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_last) n_state = S_PROBE;
            end
            S_PROBE: n_state = S_SCAN;
            S_SCAN: begin
                if (last_row) n_state = S_NBR;
            end
            S_NBR: begin
                priority if (left_ok)  n_state = S_LEFT;
                else if (right_ok)     n_state = S_RIGHT;
                else                   n_state = S_DONE;
            end
            S_LEFT: begin
                priority if (gt)       n_state = S_PROBE;
                else if (right_ok)     n_state = S_RIGHT;
                else                   n_state = S_DONE;
            end
            S_RIGHT: n_state = gt ? S_PROBE : S_DONE;
            S_DONE: begin
                if (!i_out_full) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_status.in_ready = 1'b0;
        o_status.done     = 1'b0;
        wr_en             = 1'b0;
        rd_addr           = '0;
        unique case (r_state)
            S_LOAD: begin
                o_status.in_ready = 1'b1;
                wr_en             = i_in_valid;
            end
            S_PROBE: rd_addr = ADDR_W'(mid);
            S_SCAN:  rd_addr = r_addr + ADDR_W'(i_cols);
            S_NBR:   rd_addr = left_ok ? (r_best_addr - 1'b1) : (r_best_addr + 1'b1);
            S_LEFT:  rd_addr = r_best_addr + 1'b1;
            S_RIGHT: rd_addr = '0;
            S_DONE:  o_status.done = !i_out_full;
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_pos <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                // wrap when the matrix is overfilled, restart after a search
                if (i_last || pos_inc >= total) r_load_pos <= '0;
                else                            r_load_pos <= ADDR_W'(pos_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                if (in_xfer && i_last) begin
                    r_low  <= '0;
                    r_high <= COL_W'(i_cols - 1'b1);
                end
            end
            S_PROBE: begin
                r_probe <= mid;
                r_addr  <= ADDR_W'(mid);
                r_row   <= '0;
            end
            S_SCAN: begin
                if (take) begin
                    r_best_val  <= rd_data;
                    r_best_row  <= r_row;
                    r_best_addr <= r_addr;
                end
                r_addr <= r_addr + ADDR_W'(i_cols);
                r_row  <= r_row + 1'b1;
            end
            S_LEFT: begin
                if (gt) r_high <= r_probe - 1'b1;
            end
            S_RIGHT: begin
                if (gt) r_low <= r_probe + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_peak_value = r_best_val;
    assign o_peak_row   = r_best_row;
    assign o_peak_col   = r_probe;
endmodule

### hw/rtl/mpf_checker.sv
`include "matrix_peak_finder_assert.svh"

module mpf_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_in_last,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [VALUE_WIDTH-1:0] i_out_value
);
    // a stalled result holds
    `MPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value))

    // the search starts right after the final element and blocks input
    `MPF_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready)

    // a result never shows up at the edge of an input transfer
    `MPF_ASSERT_SAME(a_result_after_search, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_valid && i_in_ready))
endmodule

bind matrix_peak_finder mpf_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_elem.valid),
    .i_in_ready  (i_elem.ready),
    .i_in_last   (i_elem.last_element),
    .i_out_valid (o_peak.valid),
    .i_out_ready (o_peak.ready),
    .i_out_value (o_peak.peak_value)
);

### dv/mpf_peak_checker.sv
`timescale 1ns / 1ps

module mpf_peak_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mpf_in_if                              elem,
    mpf_out_if                             peak,
    input  logic                           i_cfg_we,
    input  logic [mpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_mismatches,
    output int                             o_peaks_checked
);
    import mpf_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         row;
        logic [5:0]         column;
    } peak_t;

    logic signed [31:0] grid [0:4095];
    logic [6:0]         rows_reg = DIM_RESET;
    logic [6:0]         cols_reg = DIM_RESET;
    int                 load_at = 0;
    peak_t              peaks_due [$];
    int                 pending_count = 0;
    int                 mismatch_count = 0;
    int                 checked_count = 0;

    assign o_pending       = pending_count;
    assign o_mismatches    = mismatch_count;
    assign o_peaks_checked = checked_count;

    initial begin
        for (int i = 0; i < 4096; i++) begin
            grid[i] = '0;
        end
    end

    function automatic int dim_used(logic [6:0] raw);
        if (raw == 0) return 1;
        if (raw > 64) return 64;
        return int'(raw);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] peak mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Store one element; on the last one, run the column bisection and queue the peak.
    task automatic load_element(logic signed [31:0] value, logic last);
        int                 rows;
        int                 cols;
        int                 total;
        int                 lo;
        int                 hi;
        int                 mid;
        int                 best_r;
        logic signed [31:0] best;
        peak_t              found;
        rows  = dim_used(rows_reg);
        cols  = dim_used(cols_reg);
        total = rows * cols;
        if (load_at >= total) load_at = 0;
        grid[load_at] = value;
        load_at++;
        if (!last) begin
            if (load_at >= total) load_at = 0;
            return;
        end
        load_at = 0;
        lo = 0;
        hi = cols - 1;
        forever begin
            mid    = (lo + hi) / 2;
            best_r = 0;
            best   = grid[mid];
            // lowest row wins on a tie
            for (int r = 1; r < rows; r++) begin
                if (grid[r * cols + mid] > best) begin
                    best   = grid[r * cols + mid];
                    best_r = r;
                end
            end
            if (mid > lo && grid[best_r * cols + mid - 1] > best) begin
                hi = mid - 1;
            end else if (mid < hi && grid[best_r * cols + mid + 1] > best) begin
                lo = mid + 1;
            end else begin
                break;
            end
        end
        found.value  = best;
        found.row    = best_r[5:0];
        found.column = mid[5:0];
        peaks_due.push_back(found);
    endtask

    task automatic check_peak();
        peak_t want;
        if (peaks_due.size() == 0) begin
            report_mismatch($sformatf("peak %0d at (%0d,%0d) with nothing pending",
                                      peak.peak_value, peak.peak_row, peak.peak_column));
            return;
        end
        want = peaks_due.pop_front();
        checked_count++;
        if (peak.peak_value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d", peak.peak_value, want.value));
        if (peak.peak_row !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", peak.peak_row, want.row));
        if (peak.peak_column !== want.column)
            report_mismatch($sformatf("column %0d, want %0d", peak.peak_column, want.column));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = DIM_RESET;
            cols_reg = DIM_RESET;
            load_at  = 0;
            peaks_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ROWS_IN_USE) rows_reg = i_cfg_data;
                else if (i_cfg_idx == REG_COLS_IN_USE) cols_reg = i_cfg_data;
            end
            if (elem.valid && elem.ready) load_element(elem.element_value, elem.last_element);
            if (peak.valid && peak.ready) check_peak();
        end
        pending_count = peaks_due.size();
    end

endmodule

### dv/matrix_peak_finder_test.sv
`timescale 1ns / 1ps

module matrix_peak_finder_test;
    import mpf_pkg::*;

    localparam int ELEMENT_TARGET = 1950;
    localparam int SEARCH_CYCLES  = 7 * (64 + 4) + 1;
    localparam int HOLD_CYCLES    = 800;
    localparam int CYCLE_LIMIT    = 2000000;

    typedef enum {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_RISING,
        FILL_FALLING,
        FILL_HILL
    } fill_t;

    typedef enum {
        SHAPE_FULL,
        SHAPE_EARLY,
        SHAPE_OVERFILL,
        SHAPE_NOISE
    } shape_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending;
    int mismatches;
    int peaks_checked;

    bit calm = 1'b0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int cycle_count = 0;

    // stimulus-side view of the load pointer and of the written prefix of the store
    int rows_now = 64;
    int cols_now = 64;
    int load_pos = 0;
    int written_hi = 0;
    int elements_sent = 0;
    int searches = 0;

    mpf_in_if  elem_if ();
    mpf_out_if peak_if ();

    matrix_peak_finder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_elem     (elem_if),
        .o_peak     (peak_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mpf_peak_checker peak_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .elem            (elem_if),
        .peak            (peak_if),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_mismatches    (mismatches),
        .o_peaks_checked (peaks_checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("matrix_peak_finder_test: errors");
            $finish;
        end
    end

    // Output side: random backpressure, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_taken != hold_asked) begin
            hold_taken = hold_taken + 1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            peak_if.ready <= 1'b0;
        end else begin
            peak_if.ready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    function automatic int dim_of(logic [6:0] raw);
        if (raw == 0) return 1;
        if (raw > 64) return 64;
        return int'(raw);
    endfunction

    function automatic logic signed [31:0] make_value(fill_t fill, int r, int c, int knee);
        int spread;
        spread = (c > knee) ? c - knee : knee - c;
        case (fill)
            FILL_RANDOM:  return $urandom;
            FILL_NARROW:  return int'($urandom_range(0, 6)) - 3;
            FILL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            FILL_RISING:  return c * 4096 + r * 8 + int'($urandom_range(0, 7));
            FILL_FALLING: return -1000000 - c * 4096 + int'($urandom_range(0, 7));
            default:      return 5000 - spread * 64 + int'($urandom_range(0, 40)) - r;
        endcase
    endfunction

    task automatic push_element(logic signed [31:0] value, logic last);
        int total;
        int pos;
        total = rows_now * cols_now;
        pos   = (load_pos >= total) ? 0 : load_pos;
        if (pos + 1 > written_hi) written_hi = pos + 1;
        // a search must never read a store entry that was not written since reset
        if (written_hi < total) last = 1'b0;
        load_pos = (last || pos + 1 >= total) ? 0 : pos + 1;
        elements_sent++;
        if (last) searches++;
        @(negedge i_clk);
        // idle cycle by cycle at random outside the calm stretch
        while (!calm && $urandom_range(0, 99) < 29) begin
            elem_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        elem_if.valid         <= 1'b1;
        elem_if.element_value <= value;
        elem_if.last_element  <= last;
        @(posedge i_clk);
        while (!elem_if.ready) @(posedge i_clk);
    endtask

    task automatic send_matrix(shape_t shape, fill_t fill);
        int   total;
        int   count;
        int   pos;
        int   knee;
        logic last;
        total = rows_now * cols_now;
        knee  = $urandom_range(0, cols_now - 1);
        case (shape)
            SHAPE_FULL:     count = total;
            SHAPE_EARLY:    count = $urandom_range(1, total);
            SHAPE_OVERFILL: count = total + $urandom_range(1, total);
            default:        count = $urandom_range(1, 2 * total);
        endcase
        for (int i = 0; i < count; i++) begin
            pos = (load_pos >= total) ? 0 : load_pos;
            if (shape == SHAPE_NOISE) last = ($urandom_range(0, 3) == 0);
            else last = (i == count - 1);
            push_element(make_value(fill, pos / cols_now, pos % cols_now, knee), last);
        end
    endtask

    // Drop valid and wait until every queued peak has come out.
    task automatic settle();
        @(negedge i_clk);
        elem_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_dims(logic [6:0] rows_raw, logic [6:0] cols_raw);
        settle();
        write_reg(REG_ROWS_IN_USE, rows_raw);
        write_reg(REG_COLS_IN_USE, cols_raw);
        rows_now = dim_of(rows_raw);
        cols_now = dim_of(cols_raw);
    endtask

    initial begin
        int         phase_no;
        int         mats;
        int         pick;
        logic [6:0] rows_raw;
        logic [6:0] cols_raw;
        shape_t     shape;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = '0;
        cfg_data              = '0;
        elem_if.valid         = 1'b0;
        elem_if.element_value = '0;
        elem_if.last_element  = 1'b0;
        peak_if.ready         = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-cell matrix with the value extremes
        set_dims(7'd1, 7'd1);
        push_element(32'sh7fff_ffff, 1'b1);
        push_element(32'sh8000_0000, 1'b1);
        push_element(32'sh0, 1'b1);
        // peaks at the right and at the left edge
        set_dims(7'd2, 7'd3);
        send_matrix(SHAPE_FULL, FILL_RISING);
        set_dims(7'd3, 7'd2);
        send_matrix(SHAPE_FULL, FILL_FALLING);
        // search started before the matrix is complete
        set_dims(7'd1, 7'd4);
        push_element(make_value(FILL_NARROW, 0, 0, 0), 1'b0);
        push_element(make_value(FILL_NARROW, 0, 1, 0), 1'b1);
        // load pointer wraps and overwrites
        set_dims(7'd1, 7'd2);
        push_element(make_value(FILL_EXTREME, 0, 0, 0), 1'b0);
        push_element(make_value(FILL_EXTREME, 0, 1, 0), 1'b0);
        push_element(make_value(FILL_EXTREME, 0, 0, 0), 1'b1);

        phase_no = 0;
        while (elements_sent < ELEMENT_TARGET) begin
            if (phase_no == 1) begin
                rows_raw = 7'd2;
                cols_raw = 7'd2;
            end else if (phase_no % 7 == 3) begin
                case ((phase_no / 7) % 4)
                    0:       begin rows_raw = 7'd64;  cols_raw = 7'd2;   end
                    1:       begin rows_raw = 7'd2;   cols_raw = 7'd64;  end
                    2:       begin rows_raw = 7'd0;   cols_raw = 7'd100; end
                    default: begin rows_raw = 7'd127; cols_raw = 7'd1;   end
                endcase
            end else if ($urandom_range(0, 4) == 0) begin
                rows_raw = 7'($urandom_range(1, 16));
                cols_raw = 7'($urandom_range(1, 16));
            end else begin
                rows_raw = 7'($urandom_range(0, 8));
                cols_raw = 7'($urandom_range(0, 8));
            end
            set_dims(rows_raw, cols_raw);
            calm = (phase_no == 5);
            if (phase_no == 1) begin
                // hold the output so the block fills and stalls the input
                hold_asked = hold_asked + 1;
                repeat (8) send_matrix(SHAPE_FULL, FILL_RANDOM);
            end else begin
                mats = calm ? 8 : $urandom_range(1, 4);
                repeat (mats) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) shape = SHAPE_FULL;
                    else if (pick < 80) shape = SHAPE_EARLY;
                    else if (pick < 90) shape = SHAPE_OVERFILL;
                    else shape = SHAPE_NOISE;
                    send_matrix(shape, fill_t'($urandom_range(0, 5)));
                end
            end
            phase_no++;
        end

        settle();
        repeat (SEARCH_CYCLES) @(negedge i_clk);
        $display("summary: %0d elements, %0d searches, %0d peaks compared",
                 elements_sent, searches, peaks_checked);
        $display("summary: 1 to 64 rows and columns, early and overfilled loads, long output stall");
        if (mismatches == 0) begin
            $display("matrix_peak_finder_test: clean");
        end else begin
            $display("matrix_peak_finder_test: errors");
        end
        $finish;
    end

endmodule
